[rtl/core/spli_pkg.sv]
// Shared types and constants for the linear-interpolation sample player.
// No dependencies; imported by the core and its checker.
package spli_pkg;

    localparam int SAMPLE_BITS    = 16;
    localparam int FRAC_BITS      = 16;
    localparam int STORE_DEPTH    = 4096;
    localparam int ADDR_BITS      = 12;
    localparam int FRAME_BITS     = 13;
    localparam int POS_BITS       = 28;
    localparam int RATE_BITS      = 27;
    localparam int GAIN_BITS      = 16;
    localparam int CFG_DATA_BITS  = 27;
    localparam int CFG_INDEX_BITS = 3;
    localparam int MAX_RATE_INT   = 1024;
    localparam int UNITY_GAIN     = 32768;

    localparam logic [RATE_BITS-1:0] RATE_ONE = RATE_BITS'(1) << FRAC_BITS;
    localparam logic [RATE_BITS-1:0] RATE_MAX = RATE_BITS'(MAX_RATE_INT) << FRAC_BITS;
    localparam logic [GAIN_BITS-1:0] GAIN_MAX = GAIN_BITS'(UNITY_GAIN);

    // Function codes of an input word
    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_RENDER = 2'd1;
    localparam logic [1:0] FUNC_START  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOOP_ENABLE   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOOP_START    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_LOOP_END      = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_END_FRAME     = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_BUFFER_LENGTH = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PITCH_RATE    = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN          = 3'd6;

    typedef struct packed {
        logic [1:0]                    func;
        logic [ADDR_BITS-1:0]          address;
        logic signed [SAMPLE_BITS-1:0] sample_in;
    } spli_in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample_out;
        logic                          finished;
    } spli_out_t;

endpackage

[rtl/core/spli_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spli_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/core/sample_player_linear_interp_core.sv]
// Mono sample player core: sample store, read position, interpolation datapath.
// Depends on spli_pkg and spli_ram.
//
// Usage:
//   Input words (s_valid/s_ready/s_data) carry a function code: load writes
//   sample_in to the store at address, start puts the read position on frame
//   address and clears finished, render produces one interpolated, gained,
//   rounded and saturated frame and advances the position by the pitch rate.
//   Every input word yields exactly one output word (m_valid/m_ready/m_data);
//   sample_out is zero for anything but a productive render. Configuration
//   is written through cfg_wr_en/cfg_index/cfg_wdata, one register per cycle;
//   the user must write only while the core is idle; the core does not enforce it.
// Sequencing:
//   Load, start, no-op and silent renders skip the multiply states. A sounding
//   render makes two reads through the single store read port, then two
//   passes through one shared 34x17 multiplier (difference times fraction,
//   then mix times gain), then rounds and saturates. s_ready is high only
//   while the sequencer is idle, so one word is in flight at a time; the
//   next word may be accepted while the output register still holds an
//   untaken result.
// Reset and stall:
//   aresetn (synchronous, active low) clears position, finished flag, the
//   sequencer and output valid, and restores register defaults; the store is
//   not cleared. While the receiver stalls, the output word holds and the
//   sequencer waits with its finished result before taking more input.
module sample_player_linear_interp_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  spli_pkg::spli_in_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output spli_pkg::spli_out_t                m_data,
    input  logic                               cfg_wr_en,
    input  logic [spli_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [spli_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

    import spli_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PREP = 3'd1;
    localparam logic [2:0] ST_RD2  = 3'd2;
    localparam logic [2:0] ST_MUL1 = 3'd3;
    localparam logic [2:0] ST_MUL2 = 3'd4;
    localparam logic [2:0] ST_SAT  = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    // Configuration registers
    logic                  loop_enable_reg;
    logic [FRAME_BITS-1:0] loop_start_reg;
    logic [FRAME_BITS-1:0] loop_end_reg;
    logic [FRAME_BITS-1:0] end_frame_reg;
    logic [FRAME_BITS-1:0] buffer_length_reg;
    logic [RATE_BITS-1:0]  pitch_rate_reg;
    logic [GAIN_BITS-1:0]  gain_reg;

    // Control and state
    logic [2:0]          state_reg, state_next;
    logic [POS_BITS-1:0] pos_reg;
    logic                done_reg;
    logic                m_valid_reg;
    spli_out_t           m_data_reg;

    // Datapath registers
    logic signed [SAMPLE_BITS-1:0] s1_reg;
    logic signed [47:0]            mul_reg;
    logic [POS_BITS:0]             pos_sum_reg;
    logic signed [SAMPLE_BITS-1:0] res_reg;

    logic s_fire;
    assign s_fire  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loop_enable_reg   <= 1'b0;
            loop_start_reg    <= '0;
            loop_end_reg      <= '0;
            end_frame_reg     <= FRAME_BITS'(STORE_DEPTH);
            buffer_length_reg <= FRAME_BITS'(STORE_DEPTH);
            pitch_rate_reg    <= RATE_ONE;
            gain_reg          <= GAIN_MAX;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_LOOP_ENABLE:   loop_enable_reg   <= cfg_wdata[0];
                REG_LOOP_START:    loop_start_reg    <= cfg_wdata[FRAME_BITS-1:0];
                REG_LOOP_END:      loop_end_reg      <= cfg_wdata[FRAME_BITS-1:0];
                REG_END_FRAME:     end_frame_reg     <= cfg_wdata[FRAME_BITS-1:0];
                REG_BUFFER_LENGTH: buffer_length_reg <= cfg_wdata[FRAME_BITS-1:0];
                REG_PITCH_RATE:    pitch_rate_reg    <= cfg_wdata[RATE_BITS-1:0];
                REG_GAIN:          gain_reg          <= cfg_wdata[GAIN_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Play range, loop span and clamped rate/gain; static while a word is in flight, given idle-only config writes
    logic [FRAME_BITS-1:0]  buflen, endf, vend;
    logic signed [FRAME_BITS:0] span;
    logic                   region;
    logic [RATE_BITS-1:0]   rate_eff;
    logic [GAIN_BITS-1:0]   gain_eff;
    logic [POS_BITS:0]      span_fx, vend_fx, endf_fx;
    logic                   rate_silent;

    always_comb begin
        buflen = (buffer_length_reg > FRAME_BITS'(STORE_DEPTH)) ?
                 FRAME_BITS'(STORE_DEPTH) : buffer_length_reg;
        endf   = (end_frame_reg < buflen) ? end_frame_reg : buflen;
        region = loop_enable_reg && (loop_end_reg != '0) && (loop_start_reg < loop_end_reg);
        vend   = endf;
        span   = $signed({1'b0, endf});
        if (region) begin
            if (loop_end_reg < endf) begin
                vend = loop_end_reg;
            end
            span = $signed({1'b0, vend}) - $signed({1'b0, loop_start_reg});
        end
        if (pitch_rate_reg == '0) begin
            rate_eff = RATE_ONE;
        end else if (pitch_rate_reg > RATE_MAX) begin
            rate_eff = RATE_MAX;
        end else begin
            rate_eff = pitch_rate_reg;
        end
        gain_eff    = (gain_reg > GAIN_MAX) ? GAIN_MAX : gain_reg;
        span_fx     = {span[FRAME_BITS-1:0], {FRAC_BITS{1'b0}}};
        vend_fx     = {vend, {FRAC_BITS{1'b0}}};
        endf_fx     = {endf, {FRAC_BITS{1'b0}}};
        rate_silent = (span <= 0) || ({2'b00, rate_eff} >= span_fx);
    end

    // Neighbor frame selection from the current position
    logic [ADDR_BITS-1:0]  idx;
    logic [FRAME_BITS-1:0] idx1, idx2;
    logic                  nb_silent;

    always_comb begin
        idx       = pos_reg[POS_BITS-1:FRAC_BITS];
        idx1      = {1'b0, idx} + FRAME_BITS'(1);
        idx2      = idx1;
        nb_silent = 1'b0;
        if (idx1 >= buflen) begin
            if (loop_enable_reg) begin
                // wrap the right neighbor back into the loop
                if (span > $signed({1'b0, idx1})) begin
                    nb_silent = 1'b1;
                end
                idx2 = idx1 - span[FRAME_BITS-1:0];
            end else begin
                idx2 = {1'b0, idx};
            end
        end
        if (({1'b0, idx} >= buflen) || (idx2 >= buflen)) begin
            nb_silent = 1'b1;
        end
    end

    // Sample store: written on load, read twice per sounding render
    logic                   ram_we;
    logic [ADDR_BITS-1:0]   ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    assign ram_we    = s_fire && (s_data.func == FUNC_LOAD) &&
                       ({1'b0, s_data.address} < FRAME_BITS'(STORE_DEPTH));
    assign ram_raddr = (state_reg == ST_PREP) ? idx : idx2[ADDR_BITS-1:0];

    spli_ram #(
        .WIDTH(SAMPLE_BITS),
        .DEPTH(STORE_DEPTH)
    ) u_store (
        .clk  (aclk),
        .we   (ram_we),
        .waddr(s_data.address),
        .wdata(s_data.sample_in),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Shared multiplier: pass one is (s2 - s1) * frac, pass two is mix * gain
    logic signed [SAMPLE_BITS:0] diff;
    logic signed [33:0]          mix;
    logic signed [33:0]          mul_a;
    logic signed [16:0]          mul_b;
    logic signed [50:0]          mul_p;

    always_comb begin
        diff = $signed({ram_rdata[SAMPLE_BITS-1], ram_rdata}) -
               $signed({s1_reg[SAMPLE_BITS-1], s1_reg});
        mix  = $signed({{2{s1_reg[SAMPLE_BITS-1]}}, s1_reg, {FRAC_BITS{1'b0}}}) +
               mul_reg[33:0];
        if (state_reg == ST_MUL1) begin
            mul_a = $signed({{17{diff[SAMPLE_BITS]}}, diff});
            mul_b = $signed({1'b0, pos_reg[FRAC_BITS-1:0]});
        end else begin
            mul_a = mix;
            mul_b = $signed({1'b0, gain_eff});
        end
        mul_p = mul_a * mul_b;
    end

    // Round half up, drop FRAC_BITS+15 bits, saturate
    logic signed [47:0] rnd;
    logic signed [16:0] quo;
    logic signed [SAMPLE_BITS-1:0] sat;

    always_comb begin
        rnd = mul_reg + 48'sd1073741824;
        quo = rnd[47:31];
        if (quo[16] != quo[15]) begin
            sat = quo[16] ? 16'sh8000 : 16'sh7FFF;
        end else begin
            sat = quo[15:0];
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = (s_data.func == FUNC_RENDER && !done_reg) ? ST_PREP : ST_OUT;
                end
            end
            ST_PREP: state_next = (rate_silent || nb_silent) ? ST_OUT : ST_RD2;
            ST_RD2:  state_next = ST_MUL1;
            ST_MUL1: state_next = ST_MUL2;
            ST_MUL2: state_next = ST_SAT;
            ST_SAT:  state_next = ST_OUT;
            ST_OUT:  state_next = (!m_valid_reg || m_ready) ? ST_IDLE : ST_OUT;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            done_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire && s_data.func == FUNC_START) begin
                        pos_reg  <= {s_data.address, {FRAC_BITS{1'b0}}};
                        done_reg <= 1'b0;
                    end else if (s_fire && s_data.func == FUNC_RENDER && !done_reg) begin
                        // position at or past the play end restarts at frame zero
                        if ({1'b0, pos_reg} >= endf_fx) begin
                            pos_reg <= '0;
                        end
                    end
                end
                ST_MUL2: begin
                    if (pos_sum_reg >= vend_fx) begin
                        pos_reg <= POS_BITS'(pos_sum_reg - span_fx);
                        if (!loop_enable_reg) begin
                            done_reg <= 1'b1;
                        end
                    end else begin
                        pos_reg <= pos_sum_reg[POS_BITS-1:0];
                    end
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: res_reg <= '0;
            ST_RD2:  s1_reg  <= ram_rdata;
            ST_MUL1: begin
                mul_reg     <= $signed(mul_p[47:0]);
                pos_sum_reg <= {1'b0, pos_reg} + {2'b00, rate_eff};
            end
            ST_MUL2: mul_reg <= $signed(mul_p[47:0]);
            ST_SAT:  res_reg <= sat;
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_data_reg.sample_out <= res_reg;
                    m_data_reg.finished   <= done_reg;
                end
            end
            default: ;
        endcase
    end

endmodule

[rtl/core/spli_checker.sv]
// Port-level checks for the sample player core, bound to its top level.
// Depends on spli_pkg and sample_player_linear_interp_core.
module spli_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input spli_pkg::spli_out_t m_data
);

    import spli_pkg::*;

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("output word changed while stalled");

    // Drop ready after taking a word: one word in flight
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while busy");

    // A new result only appears after the sequencer was busy
    a_result_after_work: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> !$past(s_ready))
        else $error("result appeared without a word in flight");

    // Reset clears output valid
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind sample_player_linear_interp_core spli_checker u_spli_checker (.*);

[test/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for the linear-interpolation sample player core.
// Depends on spli_pkg and sample_player_linear_interp_core; uses nothing else.
module tb_top;
    import spli_pkg::*;

    typedef longint unsigned u64_t;

    localparam int CLK_HALF    = 5;
    localparam int QUIET_LIMIT = 4000;   // cycles with no handshake before giving up
    localparam int HOLD_CYCLES = 300;    // long receiver hold-off used once
    localparam int NUM_SEGS    = 30;
    localparam int SEG_WORDS   = 61;
    localparam int TAIL_CYCLES = 8;
    localparam int MAX_REPORTS = 200;

    // No-op code; the package only names the three working functions
    localparam logic [1:0] FUNC_NOP = 2'd3;

    // One full register setting of the player
    typedef struct {
        logic                  loop_en;
        logic [FRAME_BITS-1:0] loop_start;
        logic [FRAME_BITS-1:0] loop_end;
        logic [FRAME_BITS-1:0] end_frame;
        logic [FRAME_BITS-1:0] buffer_length;
        logic [RATE_BITS-1:0]  pitch_rate;
        logic [GAIN_BITS-1:0]  gain;
    } play_cfg_t;

    // Directed stimulus row: either a register setting or one input word
    typedef struct {
        int        setting;   // index into dir_cfgs, or -1 for a word row
        spli_in_t  word;
        bit        typed;     // known holds the hand-computed result
        spli_out_t known;
    } stim_row_t;

    // DUT signals; every input starts at a known value
    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    spli_in_t   s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    spli_out_t  m_data;
    logic       cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;

    // Predictor state: our own copy of the store, position, flag and registers
    logic signed [SAMPLE_BITS-1:0] sample_mem [STORE_DEPTH];
    bit        sample_known [STORE_DEPTH];
    u64_t      play_pos  = 0;
    bit        play_done = 1'b0;
    play_cfg_t cfg_now;

    // Results still owed by the core, oldest first
    spli_out_t due_words [$];
    spli_out_t want;

    stim_row_t stim_rows [$];
    play_cfg_t dir_cfgs  [4];

    int unsigned src_idle_pct  = 0;
    int unsigned sink_stall_pct = 0;
    int          hold_req      = 0;
    int          hold_left     = 0;
    int          errors        = 0;
    int          words_sent    = 0;
    int          results_seen  = 0;
    int          sounding      = 0;
    int          settings_used = 0;

    int unsigned src_idle_tab [4] = '{0, 68, 0, 18};
    int unsigned sink_stall_tab [4] = '{0, 0, 68, 18};

    always #CLK_HALF aclk = ~aclk;

    sample_player_linear_interp_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Render one frame from the current position. With commit low nothing is
    // updated; the caller only learns which store frames a render would read.
    function automatic logic signed [SAMPLE_BITS-1:0] play_frame(
        input bit commit, output bit touched, output int unsigned rd_a,
        output int unsigned rd_b);
        u64_t    pos, buflen, endf, vend, rate, idx, idx2, frac, g;
        longint  span, s1, s2, mix, prod;
        bit      looping, done, ok;
        logic signed [SAMPLE_BITS-1:0] smp;
        pos     = play_pos;
        done    = play_done;
        touched = 1'b0;
        rd_a    = 0;
        rd_b    = 0;
        smp     = '0;
        looping = cfg_now.loop_en;
        buflen  = (cfg_now.buffer_length > STORE_DEPTH) ? STORE_DEPTH : cfg_now.buffer_length;
        endf    = (cfg_now.end_frame > buflen) ? buflen : cfg_now.end_frame;
        vend    = endf;
        span    = longint'(endf);
        // a finished non-looping voice stays silent until the next start
        if (!done) begin
            // restart from frame zero when the position sits at or past the end
            if (pos >= (endf << FRAC_BITS))
                pos = 0;
            if (looping && cfg_now.loop_end != 0 && cfg_now.loop_start < cfg_now.loop_end) begin
                if (cfg_now.loop_end < vend)
                    vend = cfg_now.loop_end;
                span = longint'(vend) - longint'(cfg_now.loop_start);
            end
            rate = cfg_now.pitch_rate;
            if (rate == 0)
                rate = RATE_ONE;
            if (rate > RATE_MAX)
                rate = RATE_MAX;
            // a step of a whole span or more gives silence and keeps the position
            if (span > 0 && rate < (u64_t'(span) << FRAC_BITS)) begin
                idx  = pos >> FRAC_BITS;
                frac = pos & ((u64_t'(1) << FRAC_BITS) - 1);
                idx2 = idx + 1;
                ok   = 1'b1;
                // right neighbour past the buffer: wrap when looping, else repeat
                if (idx2 >= buflen) begin
                    if (!looping)
                        idx2 = idx;
                    else if (u64_t'(span) > idx + 1)
                        ok = 1'b0;
                    else
                        idx2 = idx + 1 - u64_t'(span);
                end
                if (idx >= buflen || idx2 >= buflen)
                    ok = 1'b0;
                if (ok) begin
                    touched = 1'b1;
                    rd_a    = idx;
                    rd_b    = idx2;
                    s1      = sample_mem[idx];
                    s2      = sample_mem[idx2];
                    mix     = s1 * longint'((u64_t'(1) << FRAC_BITS) - frac)
                            + s2 * longint'(frac);
                    g       = (cfg_now.gain > GAIN_MAX) ? GAIN_MAX : cfg_now.gain;
                    // round half up, then floor shift
                    prod    = mix * longint'(g) + (longint'(1) << (FRAC_BITS + 14));
                    prod    = prod >>> (FRAC_BITS + 15);
                    if (prod > longint'((1 << (SAMPLE_BITS - 1)) - 1))
                        prod = longint'((1 << (SAMPLE_BITS - 1)) - 1);
                    if (prod < -longint'(1 << (SAMPLE_BITS - 1)))
                        prod = -longint'(1 << (SAMPLE_BITS - 1));
                    smp     = SAMPLE_BITS'(prod);
                    // advance and wrap by the span; without looping that ends play
                    pos = pos + rate;
                    if (pos >= (vend << FRAC_BITS)) begin
                        pos = pos - (u64_t'(span) << FRAC_BITS);
                        if (!looping)
                            done = 1'b1;
                    end
                end
            end
        end
        if (commit) begin
            play_pos  = pos;
            play_done = done;
        end
        return smp;
    endfunction

    // Apply one accepted input word to the predictor and return its result
    function automatic spli_out_t play_word(input spli_in_t w);
        spli_out_t   r;
        bit          rd;
        int unsigned a, b;
        r.sample_out = '0;
        case (w.func)
            FUNC_LOAD: begin
                sample_mem[w.address]   = w.sample_in;
                sample_known[w.address] = 1'b1;
            end
            FUNC_RENDER: begin
                r.sample_out = play_frame(1'b1, rd, a, b);
                if (rd)
                    sounding++;
            end
            FUNC_START: begin
                play_pos  = u64_t'(w.address) << FRAC_BITS;
                play_done = 1'b0;
            end
            default: ;
        endcase
        r.finished = play_done;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic play_cfg_t mk_cfg(input int unsigned en, input int unsigned ls,
                                         input int unsigned le, input int unsigned ef,
                                         input int unsigned bl, input int unsigned rate,
                                         input int unsigned gn);
        play_cfg_t c;
        c.loop_en       = en[0];
        c.loop_start    = FRAME_BITS'(ls);
        c.loop_end      = FRAME_BITS'(le);
        c.end_frame     = FRAME_BITS'(ef);
        c.buffer_length = FRAME_BITS'(bl);
        c.pitch_rate    = RATE_BITS'(rate);
        c.gain          = GAIN_BITS'(gn);
        return c;
    endfunction

    function automatic stim_row_t word_row(input logic [1:0] f, input int addr,
                                           input int smp);
        stim_row_t r;
        r.setting        = -1;
        r.word.func      = f;
        r.word.address   = ADDR_BITS'(addr);
        r.word.sample_in = SAMPLE_BITS'(smp);
        r.typed          = 1'b0;
        r.known          = '0;
        return r;
    endfunction

    function automatic stim_row_t typed_row(input logic [1:0] f, input int addr,
                                            input int smp, input int out, input bit fin);
        stim_row_t r;
        r                  = word_row(f, addr, smp);
        r.typed            = 1'b1;
        r.known.sample_out = SAMPLE_BITS'(out);
        r.known.finished   = fin;
        return r;
    endfunction

    function automatic stim_row_t setup_row(input int idx);
        stim_row_t r;
        r         = word_row(FUNC_NOP, 0, 0);
        r.setting = idx;
        return r;
    endfunction

    // Random register setting; the first segments pin the extremes
    function automatic play_cfg_t rand_setting(input int seg);
        play_cfg_t   c;
        int unsigned len, endf, eff, r, rate;
        len  = ($urandom_range(7) == 0) ? $urandom_range(1, STORE_DEPTH) : $urandom_range(2, 40);
        endf = ($urandom_range(3) == 0) ? STORE_DEPTH : $urandom_range(1, len);
        eff  = (endf < len) ? endf : len;
        c.loop_en       = $urandom_range(1);
        c.buffer_length = FRAME_BITS'(len);
        c.end_frame     = FRAME_BITS'(endf);
        c.loop_start    = FRAME_BITS'($urandom_range(eff - 1));
        c.loop_end      = FRAME_BITS'($urandom_range(c.loop_start + 1, eff));
        r = $urandom_range(9);
        if (r == 0) begin
            c.loop_end = '0;
        end else if (r == 1) begin
            c.loop_start = FRAME_BITS'($urandom_range(STORE_DEPTH));
            c.loop_end   = FRAME_BITS'($urandom_range(STORE_DEPTH));
        end
        r = $urandom_range(19);
        if (r < 12)
            rate = $urandom_range(32'h2000, 32'h30000);
        else if (r < 14)
            rate = 0;
        else if (r < 17)
            rate = $urandom_range((eff > 1023) ? 32'h400_0000 : eff << FRAC_BITS);
        else if (r < 19)
            rate = $urandom_range(32'h400_0000);
        else
            rate = 32'h7FF_FFFF;
        c.pitch_rate = RATE_BITS'(rate);
        c.gain = ($urandom_range(3) == 0) ? GAIN_BITS'($urandom_range(16'hFFFF))
                                          : GAIN_BITS'($urandom_range(16384, UNITY_GAIN));
        case (seg)
            0: c = mk_cfg(0, 0, 0, 1, 1, 32'h8000, UNITY_GAIN);
            1: c = mk_cfg(1, 4096, 4096, 4096, 4096, 32'h10000, UNITY_GAIN);
            2: c = mk_cfg(1, 0, 0, 4096, 4096, 32'h400_0000, 0);
            3: c = mk_cfg(1, 4095, 4096, 4096, 4096, 32'h1000, 16'hFFFF);
            4: c.pitch_rate = '0;
            default: ;
        endcase
        return c;
    endfunction

    // Next random word: mostly start-then-render play with loads mixed in.
    // A render that would read a never-written frame becomes a load of it.
    function automatic spli_in_t pick_word();
        spli_in_t    w;
        int unsigned r, buflen, lim, a, b;
        bit          rd;
        logic signed [SAMPLE_BITS-1:0] unused;
        buflen = (cfg_now.buffer_length > STORE_DEPTH) ? STORE_DEPTH : cfg_now.buffer_length;
        lim    = (cfg_now.end_frame < buflen) ? cfg_now.end_frame : buflen;
        if (lim == 0)
            lim = 1;
        w.func      = FUNC_RENDER;
        w.address   = ADDR_BITS'($urandom);
        w.sample_in = SAMPLE_BITS'($urandom);
        r = $urandom_range(99);
        if (play_done && r < 40)
            r = 0;
        if (r < 8) begin
            w.func    = FUNC_START;
            w.address = ADDR_BITS'($urandom_range(lim - 1));
        end else if (r < 12) begin
            w.func = FUNC_START;
        end else if (r < 20) begin
            w.func    = FUNC_LOAD;
            w.address = ADDR_BITS'($urandom_range(buflen - 1));
        end else if (r < 24) begin
            w.func = FUNC_LOAD;
        end else if (r < 26) begin
            w.func = FUNC_NOP;
        end
        if (w.func == FUNC_RENDER) begin
            unused = play_frame(1'b0, rd, a, b);
            if (rd && !(sample_known[a] && sample_known[b])) begin
                w.func    = FUNC_LOAD;
                w.address = ADDR_BITS'(sample_known[a] ? b : a);
            end
        end
        return w;
    endfunction

    // Offer one word, hold it until taken, then log what the core owes for it
    task automatic send_word(input spli_in_t w, input bit typed, input spli_out_t known);
        spli_out_t got;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        got = play_word(w);
        due_words.push_back(typed ? known : got);
        words_sent++;
    endtask

    // Drop valid and wait until every owed result has been taken
    task automatic drain_words();
        s_valid <= 1'b0;
        while (due_words.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic apply_setting(input play_cfg_t c);
        write_reg(REG_LOOP_ENABLE,   CFG_DATA_BITS'(c.loop_en));
        write_reg(REG_LOOP_START,    CFG_DATA_BITS'(c.loop_start));
        write_reg(REG_LOOP_END,      CFG_DATA_BITS'(c.loop_end));
        write_reg(REG_END_FRAME,     CFG_DATA_BITS'(c.end_frame));
        write_reg(REG_BUFFER_LENGTH, CFG_DATA_BITS'(c.buffer_length));
        write_reg(REG_PITCH_RATE,    CFG_DATA_BITS'(c.pitch_rate));
        write_reg(REG_GAIN,          CFG_DATA_BITS'(c.gain));
        cfg_wr_en <= 1'b0;
        cfg_now = c;
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Result side: check every taken word, then choose the next ready
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (due_words.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: result with none owed: sample_out %0d finished %0b",
                             $time, m_data.sample_out, m_data.finished);
            end else begin
                want = due_words.pop_front();
                if (m_data.sample_out !== want.sample_out) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: sample_out mismatch, expected %0d, got %0d",
                                 $time, want.sample_out, m_data.sample_out);
                end
                if (m_data.finished !== want.finished) begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: finished mismatch, expected %0b, got %0b",
                                 $time, want.finished, m_data.finished);
                end
            end
        end
        // pick up a long hold-off request; count it down here
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Watchdog: give up after a long stretch with no handshake at all
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || cfg_wr_en || (s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no handshake for %0d cycles, %0d results still owed",
                 $time, QUIET_LIMIT, due_words.size());
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        spli_in_t w;
        cfg_now = mk_cfg(0, 0, 0, STORE_DEPTH, STORE_DEPTH, 32'h10000, UNITY_GAIN);

        // Hold reset first, then release it for good
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Settings for the directed rows: a short loop with a fractional
        // step at half gain; a tiny wrapping buffer with gain above unity;
        // a step as long as the span; a step past the rate ceiling at zero gain
        dir_cfgs[0] = mk_cfg(1, 2, 4, 4096, 4096, 32'h18000, 16384);
        dir_cfgs[1] = mk_cfg(1, 0, 0, 4, 4, 32'h8000, 16'hFFFF);
        dir_cfgs[2] = mk_cfg(0, 0, 0, 4, 4, 32'h40000, UNITY_GAIN);
        dir_cfgs[3] = mk_cfg(0, 0, 0, 4096, 4096, 32'h7FF_FFFF, 0);

        // Fill the frames the directed renders read, extremes of address and sample
        stim_rows.push_back(typed_row(FUNC_LOAD, 0, 32767, 0, 1'b0));
        stim_rows.push_back(typed_row(FUNC_LOAD, 1, -32768, 0, 1'b0));
        stim_rows.push_back(typed_row(FUNC_LOAD, 2, 100, 0, 1'b0));
        stim_rows.push_back(typed_row(FUNC_LOAD, 3, 7, 0, 1'b0));
        stim_rows.push_back(typed_row(FUNC_LOAD, 4, -200, 0, 1'b0));
        stim_rows.push_back(typed_row(FUNC_LOAD, 4094, 4660, 0, 1'b0));
        stim_rows.push_back(typed_row(FUNC_LOAD, 4095, -1, 0, 1'b0));
        stim_rows.push_back(typed_row(FUNC_NOP, 4095, -1, 0, 1'b0));
        // Unity rate and gain on whole frames pass samples straight through
        stim_rows.push_back(typed_row(FUNC_RENDER, 0, 0, 32767, 1'b0));
        stim_rows.push_back(typed_row(FUNC_RENDER, 0, 0, -32768, 1'b0));
        stim_rows.push_back(typed_row(FUNC_START, 4094, 0, 0, 1'b0));
        stim_rows.push_back(typed_row(FUNC_RENDER, 0, 0, 4660, 1'b0));
        // Last frame repeats itself as neighbour, and this render finishes play
        stim_rows.push_back(typed_row(FUNC_RENDER, 0, 0, -1, 1'b1));
        // Finished voice stays silent
        stim_rows.push_back(typed_row(FUNC_RENDER, 0, 0, 0, 1'b1));
        // Loop region wrap with rounding at half gain
        stim_rows.push_back(setup_row(0));
        stim_rows.push_back(typed_row(FUNC_START, 3, 0, 0, 1'b0));
        stim_rows.push_back(word_row(FUNC_RENDER, 0, 0));
        stim_rows.push_back(word_row(FUNC_RENDER, 0, 0));
        // Neighbour wraps to frame zero at the buffer end; start past the end
        stim_rows.push_back(setup_row(1));
        stim_rows.push_back(word_row(FUNC_START, 3, 0));
        stim_rows.push_back(word_row(FUNC_RENDER, 0, 0));
        stim_rows.push_back(word_row(FUNC_RENDER, 0, 0));
        stim_rows.push_back(word_row(FUNC_START, 4095, 0));
        stim_rows.push_back(word_row(FUNC_RENDER, 0, 0));
        // Step not below the span: silence, flag untouched
        stim_rows.push_back(setup_row(2));
        stim_rows.push_back(typed_row(FUNC_RENDER, 0, 0, 0, 1'b0));
        // Rate ceiling and zero gain
        stim_rows.push_back(setup_row(3));
        stim_rows.push_back(word_row(FUNC_START, 0, 0));
        stim_rows.push_back(word_row(FUNC_RENDER, 0, 0));

        foreach (stim_rows[i]) begin
            if (stim_rows[i].setting >= 0) begin
                drain_words();
                apply_setting(dir_cfgs[stim_rows[i].setting]);
            end else begin
                send_word(stim_rows[i].word, stim_rows[i].typed, stim_rows[i].known);
            end
        end

        // Random segments: new setting and handshake phase each time
        for (int seg = 0; seg < NUM_SEGS; seg++) begin
            drain_words();
            apply_setting(rand_setting(seg));
            src_idle_pct   = src_idle_tab[seg % 4];
            sink_stall_pct = sink_stall_tab[seg % 4];
            // hold the result side off while input keeps coming, so the core backs up
            if (seg == 5) begin
                src_idle_pct   = 0;
                sink_stall_pct = 0;
                hold_req       = HOLD_CYCLES;
            end
            for (int n = 0; n < SEG_WORDS; n++) begin
                w = pick_word();
                send_word(w, 1'b0, '0);
            end
        end

        drain_words();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (due_words.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, due_words.size());
        end

        $display("Checked %0d results for %0d input words over %0d register settings,",
                 results_seen, words_sent, settings_used);
        $display("with %0d sounding renders, four handshake phases and one long hold-off.",
                 sounding);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[sample_player_linear_interp_core.f]
rtl/core/spli_pkg.sv
rtl/core/spli_ram.sv
rtl/core/sample_player_linear_interp_core.sv
rtl/core/spli_checker.sv
test/tb_top.sv
